>>> rtl/dcb_pkg.sv
// Shared constants and types for the stereo DC-blocking filter.
package dcb_pkg;

	localparam int unsigned SampleW = 8;
	localparam int unsigned WideW   = 15;
	localparam int unsigned AlphaW  = 16;
	localparam int unsigned AccW    = 32;
	localparam int unsigned OutW    = 16;
	localparam int unsigned CountW  = 32;
	localparam int unsigned WideShift = 7;
	localparam int unsigned FracBits  = 16;

	localparam logic [AlphaW-1:0]  AlphaReset = 16'd65349;
	localparam logic [OutW-1:0]    OutMax     = 16'h7FFF;
	localparam logic [OutW-1:0]    OutMin     = 16'h8000;
	localparam logic [SampleW-1:0] RawMinReset = 8'd255;
	localparam logic [SampleW-1:0] RawMaxReset = 8'd0;

	// Per-channel filter result
	typedef struct packed {
		logic [OutW-1:0] sample;
		logic            clipped;
	} chan_res_t;

	// Window statistics after a frame
	typedef struct packed {
		logic [SampleW-1:0] raw_min;
		logic [SampleW-1:0] raw_max;
		logic [CountW-1:0]  clip_total;
	} stats_t;

endpackage

>>> rtl/stereo_dc_block_filter_top.sv
// Top level of the stereo DC-blocking filter with window statistics.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+--------------------------------------
//  s_axis   | in  | s_tvalid/s_tready  | s_tdata (samples), s_tuser (flags)
//  m_axis   | out | m_tvalid/m_tready  | m_tdata (filtered samples, stats)
//  cfg      | in  | cfg_we             | cfg_wdata = alpha_q16
//
// One frame per cycle while m_tready is high; the accepting edge loads the
// input register, and a later one loads the filter multiply-add and saturation
// into the result register, which drives m_tvalid. The 32x17 feedback multiply
// in each channel sets the cycle time. Reset clears the filter history, the
// statistics and both stage valids, and loads alpha with its default. A stall on
// m_tready holds the result register and backs up into the input register.
module stereo_dc_block_filter_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [15:0]                 s_tdata,  // left_sample, right_sample
	input  logic [1:0]                  s_tuser,  // drop, clear_stats
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// left_out, right_out, left_clipped, right_clipped, min_seen, max_seen,
	// clip_total, zero fill
	output logic [87:0]                 m_tdata,
	input  logic                        cfg_we,
	input  logic [dcb_pkg::AlphaW-1:0]  cfg_wdata
);
	import dcb_pkg::*;

	logic [AlphaW-1:0]  alpha_q;
	logic               valid_s1;
	logic [SampleW-1:0] left_s1;
	logic [SampleW-1:0] right_s1;
	logic               drop_s1;
	logic               clear_s1;
	logic               adv_s1;
	logic               out_valid_q;
	chan_res_t          left_res;
	chan_res_t          right_res;
	chan_res_t          left_q;
	chan_res_t          right_q;
	stats_t             stats;
	stats_t             stats_q;

	// Move the input stage forward when the result register is free
	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign m_tvalid = out_valid_q;

	// Hold the coefficient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= AlphaReset;
		end else if (cfg_we) begin
			alpha_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			left_s1  <= s_tdata[7:0];
			right_s1 <= s_tdata[15:8];
			drop_s1  <= s_tuser[0];
			clear_s1 <= s_tuser[1];
		end
	end

	dcb_chan u_left (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv_s1),
		.sample (left_s1),
		.drop   (drop_s1),
		.alpha  (alpha_q),
		.res    (left_res)
	);

	dcb_chan u_right (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv_s1),
		.sample (right_s1),
		.drop   (drop_s1),
		.alpha  (alpha_q),
		.res    (right_res)
	);

	dcb_stats u_stats (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (adv_s1),
		.left_sample   (left_s1),
		.right_sample  (right_s1),
		.drop          (drop_s1),
		.clear_stats   (clear_s1),
		.left_clipped  (left_res.clipped),
		.right_clipped (right_res.clipped),
		.stats         (stats)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			left_q  <= left_res;
			right_q <= right_res;
			stats_q <= stats;
		end
	end

	assign m_tdata = {6'd0, stats_q.clip_total, stats_q.raw_max, stats_q.raw_min,
		right_q.clipped, left_q.clipped, right_q.sample, left_q.sample};

`ifndef SYNTHESIS
	// A frame leaving the input stage is presented next cycle
	a_adv_valid: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid_q)
		else $error("result register missed a frame");

	// A clip flag always comes with a rail value
	a_left_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && left_q.clipped) |->
			(left_q.sample == OutMax || left_q.sample == OutMin))
		else $error("left clip without rail value");

	a_right_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && right_q.clipped) |->
			(right_q.sample == OutMax || right_q.sample == OutMin))
		else $error("right clip without rail value");

	// A counted frame never moves the clip total by more than two
	a_clip_step: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !clear_s1 && $past(adv_s1)) |=>
			((stats_q.clip_total - $past(stats_q.clip_total)) <= CountW'(2)))
		else $error("clip total jumped");

	// After a kept frame the window is not empty
	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !drop_s1) |=> (stats_q.raw_min <= stats_q.raw_max))
		else $error("min above max after kept frame");
`endif

endmodule

>>> rtl/dcb_chan.sv
// One channel of the DC-blocking high pass with saturation and its history registers.
module dcb_chan (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic [dcb_pkg::SampleW-1:0]    sample,
	input  logic                           drop,
	input  logic [dcb_pkg::AlphaW-1:0]     alpha,
	output dcb_pkg::chan_res_t             res
);
	import dcb_pkg::*;

	localparam int unsigned ProdW = AccW + AlphaW + 1;

	logic [WideW-1:0]        in_prev_q;
	logic [AccW-1:0]         acc_q;
	logic [WideW-1:0]        x;
	logic signed [ProdW-1:0] prod;
	logic [AccW-1:0]         fb;
	logic [AccW-1:0]         y;
	logic                    hi_clip;
	logic                    lo_clip;

	// Widen the sample, or feed zero on a dropped frame
	assign x = drop ? '0 : {sample, {WideShift{1'b0}}};

	// Feedback term: floor(y_prev * alpha / 2^16) by arithmetic shift
	assign prod = $signed(acc_q) * $signed({1'b0, alpha});
	assign fb   = prod[FracBits +: AccW];

	// New unclamped output, kept modulo 2^32
	assign y = {{(AccW-WideW){1'b0}}, x} - {{(AccW-WideW){1'b0}}, in_prev_q} + fb;

	// Saturate to signed 16 bits
	assign hi_clip = !y[AccW-1] && (|y[AccW-2:OutW-1]);
	assign lo_clip = y[AccW-1] && !(&y[AccW-2:OutW-1]);

	always_comb begin
		res.clipped = hi_clip | lo_clip;
		if (hi_clip) begin
			res.sample = OutMax;
		end else if (lo_clip) begin
			res.sample = OutMin;
		end else begin
			res.sample = y[OutW-1:0];
		end
	end

	// Advance the filter history on each processed frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_prev_q <= '0;
			acc_q     <= '0;
		end else if (en) begin
			in_prev_q <= x;
			acc_q     <= y;
		end
	end

endmodule

>>> rtl/dcb_stats.sv
// Window statistics: raw min/max and clip count, with clear.
module dcb_stats (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [dcb_pkg::SampleW-1:0] left_sample,
	input  logic [dcb_pkg::SampleW-1:0] right_sample,
	input  logic                        drop,
	input  logic                        clear_stats,
	input  logic                        left_clipped,
	input  logic                        right_clipped,
	output dcb_pkg::stats_t             stats
);
	import dcb_pkg::*;

	logic [SampleW-1:0] raw_min_q;
	logic [SampleW-1:0] raw_max_q;
	logic [CountW-1:0]  clip_q;
	logic [SampleW-1:0] base_min;
	logic [SampleW-1:0] base_max;
	logic [CountW-1:0]  base_clip;
	logic [SampleW-1:0] lo_lr;
	logic [SampleW-1:0] hi_lr;

	// Clear before this frame when asked
	assign base_min  = clear_stats ? RawMinReset : raw_min_q;
	assign base_max  = clear_stats ? RawMaxReset : raw_max_q;
	assign base_clip = clear_stats ? '0 : clip_q;

	assign lo_lr = (left_sample < right_sample) ? left_sample : right_sample;
	assign hi_lr = (left_sample > right_sample) ? left_sample : right_sample;

	// Fold in both samples unless dropped; count every clip
	always_comb begin
		stats.raw_min    = base_min;
		stats.raw_max    = base_max;
		if (!drop) begin
			if (lo_lr < base_min) begin
				stats.raw_min = lo_lr;
			end
			if (hi_lr > base_max) begin
				stats.raw_max = hi_lr;
			end
		end
		stats.clip_total = base_clip + CountW'(left_clipped) + CountW'(right_clipped);
	end

	// Hold the window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_min_q <= RawMinReset;
			raw_max_q <= RawMaxReset;
			clip_q    <= '0;
		end else if (en) begin
			raw_min_q <= stats.raw_min;
			raw_max_q <= stats.raw_max;
			clip_q    <= stats.clip_total;
		end
	end

endmodule
